/* hdl/button_press_hold_classifier_assert.svh */
// assertion macros used by the checker file
`ifndef BUTTON_PRESS_HOLD_CLASSIFIER_ASSERT_SVH
`define BUTTON_PRESS_HOLD_CLASSIFIER_ASSERT_SVH

// condition holds at every clock edge outside reset
`define BPHC_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// trigger at one edge implies the consequence at the same edge
`define BPHC_ASSERT_IMPLY(label, trig, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cons)) \
      else $error(msg);

// trigger at one edge implies the consequence at the next edge
`define BPHC_ASSERT_NEXT(label, trig, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/bphc_pkg.sv */
// types, constants and helpers for the button press/hold classifier
package bphc_pkg;

   localparam int CountWidth = 16;
   localparam int TickWidth  = 8;
   localparam int CfgWidth   = 8;
   localparam int PaddrWidth = 3;
   localparam int PdataWidth = 32;

   localparam logic [TickWidth-1:0] TickMax         = {TickWidth{1'b1}};
   localparam logic [CfgWidth-1:0]  PressTicksReset = 8'd10;
   localparam logic [CfgWidth-1:0]  HoldTicksReset  = 8'd20;

   localparam logic OpTick = 1'b0;
   localparam logic OpLoad = 1'b1;

   localparam logic RegPressTicks = 1'b0;
   localparam logic RegHoldTicks  = 1'b1;

   localparam logic [1:0] ModeCodeReleased = 2'd0;
   localparam logic [1:0] ModeCodePressed  = 2'd1;
   localparam logic [1:0] ModeCodeHeld     = 2'd2;

   localparam logic [1:0] EvPressed  = 2'd0;
   localparam logic [1:0] EvHeld     = 2'd1;
   localparam logic [1:0] EvReleased = 2'd2;

   typedef enum logic [2:0] {
      MODE_RELEASED = 3'b001,
      MODE_PRESSED  = 3'b010,
      MODE_HELD     = 3'b100
   } mode_type;

   typedef struct packed {
      logic                  op;
      logic                  button_level;
      logic [CountWidth-1:0] new_count;
   } req_type;

   typedef struct packed {
      logic                  event_valid;
      logic [1:0]            event_code;
      logic [1:0]            button_mode;
      logic [CountWidth-1:0] press_total;
   } rsp_type;

   typedef struct packed {
      mode_type              mode;
      logic [TickWidth-1:0]  tick_count;
      logic [CountWidth-1:0] press_count;
   } state_type;

   typedef struct packed {
      logic [CfgWidth-1:0] press_ticks;
      logic [CfgWidth-1:0] hold_ticks;
   } cfg_type;

   function automatic logic [1:0] mode_code(input mode_type m);
      logic [1:0] code;
      case (m)
         MODE_PRESSED: code = ModeCodePressed;
         MODE_HELD:    code = ModeCodeHeld;
         default:      code = ModeCodeReleased;
      endcase
      return code;
   endfunction

endpackage

/* hdl/bphc_csr.sv */
// configuration register file behind the apb-style port
module bphc_csr
   import bphc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [PaddrWidth-1:0] paddr,
   input  logic [PdataWidth-1:0] pwdata,
   output logic [PdataWidth-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    write_en;
   logic    reg_sel;

   assign pready   = 1'b1;
   assign write_en = psel && penable && pwrite && pready;
   assign reg_sel  = paddr[2];

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (reg_sel)
            RegPressTicks: cfg_in.press_ticks = pwdata[CfgWidth-1:0];
            RegHoldTicks:  cfg_in.hold_ticks  = pwdata[CfgWidth-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.press_ticks <= PressTicksReset;
         cfg_ff.hold_ticks  <= HoldTicksReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_sel)
         RegPressTicks: prdata = {{(PdataWidth-CfgWidth){1'b0}}, cfg_ff.press_ticks};
         RegHoldTicks:  prdata = {{(PdataWidth-CfgWidth){1'b0}}, cfg_ff.hold_ticks};
         default:       prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

/* hdl/bphc_step.sv */
// next-state and result logic for one transaction
module bphc_step
   import bphc_pkg::*;
(
   input  req_type   item,
   input  state_type cur,
   input  cfg_type   cfg,
   output state_type nxt,
   output rsp_type   result
);

   logic [TickWidth-1:0]  tick_inc;
   logic [CountWidth-1:0] count_inc;
   logic                  ev_valid;
   logic [1:0]            ev_code;

   assign tick_inc  = (cur.tick_count == TickMax) ? cur.tick_count
                                                  : cur.tick_count + {{(TickWidth-1){1'b0}}, 1'b1};
   assign count_inc = cur.press_count + {{(CountWidth-1){1'b0}}, 1'b1};

   always_comb begin
      nxt      = cur;
      ev_valid = 1'b0;
      ev_code  = EvPressed;
      if (item.op == OpLoad) begin
         nxt.press_count = item.new_count;
      end else begin
         case (cur.mode)
            MODE_PRESSED: begin
               nxt.tick_count = tick_inc;
               if (item.button_level) begin
                  if (tick_inc >= cfg.press_ticks) begin
                     ev_valid = 1'b1;
                     ev_code  = EvPressed;
                  end
                  nxt.mode = MODE_RELEASED;
               end else if (tick_inc >= cfg.hold_ticks) begin
                  nxt.mode        = MODE_HELD;
                  nxt.tick_count  = '0;
                  nxt.press_count = count_inc;
               end
            end
            MODE_HELD: begin
               nxt.tick_count = tick_inc;
               if (item.button_level) begin
                  ev_valid = 1'b1;
                  ev_code  = EvReleased;
                  nxt.mode = MODE_RELEASED;
               end else if (tick_inc >= cfg.hold_ticks) begin
                  ev_valid        = 1'b1;
                  ev_code         = EvHeld;
                  nxt.tick_count  = '0;
                  nxt.press_count = count_inc;
               end
            end
            default: begin
               nxt.mode = MODE_RELEASED;
               if (!item.button_level) begin
                  nxt.mode       = MODE_PRESSED;
                  nxt.tick_count = '0;
               end
            end
         endcase
      end
   end

   always_comb begin
      result.event_valid = ev_valid;
      result.event_code  = ev_code;
      result.button_mode = mode_code(nxt.mode);
      result.press_total = nxt.press_count;
   end

endmodule

/* hdl/button_press_hold_classifier.sv */
// top level of the button press/hold classifier
// Each request is one timer tick carrying an active-low button sample, or a load of
// the press count. The block keeps a released/pressed/held mode, a saturating 8-bit
// tick counter and a wrapping press count, and returns exactly one response per
// request with the event seen on that tick, the new mode and the press count.
// A request is registered on acceptance, evaluated from that register and written to
// the response register. One request is taken every cycle as long as rsp_stall
// stays low; a stalled response holds the request register and then req_stall. The
// user writes press_ticks (0x0) and hold_ticks (0x4) over the apb-style port only
// while no transaction is in flight; the block itself does not enforce it.
module button_press_hold_classifier
   import bphc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [PaddrWidth-1:0] paddr,
   input  logic [PdataWidth-1:0] pwdata,
   output logic [PdataWidth-1:0] prdata,
   output logic                  pready
);

   cfg_type   cfg;
   req_type   item_ff;
   logic      item_valid_ff;
   logic      item_valid_in;
   state_type state_ff;
   state_type state_nxt;
   rsp_type   result;
   rsp_type   rsp_ff;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;
   logic      advance;
   logic      take;

   bphc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   bphc_step u_step (
      .item   (item_ff),
      .cur    (state_ff),
      .cfg    (cfg),
      .nxt    (state_nxt),
      .result (result)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = item_valid_ff && out_free;
   assign req_stall = item_valid_ff && !out_free;
   assign take      = req_valid && !req_stall;

   assign item_valid_in = take || (item_valid_ff && !advance);
   assign rsp_valid_in  = advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff        <= 1'b0;
         rsp_valid_ff         <= 1'b0;
         state_ff.mode        <= MODE_RELEASED;
         state_ff.tick_count  <= '0;
         state_ff.press_count <= '0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_nxt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= req_data;
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* hdl/bphc_checker.sv */
// port-level checker for the button press/hold classifier and its bind
`include "button_press_hold_classifier_assert.svh"

module bphc_checker
   import bphc_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // stalled response stays put
   `BPHC_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled response changed")

   // request side only backs up behind a stalled response
   `BPHC_ASSERT_IMPLY(a_stall_cause, req_stall, rsp_valid && rsp_stall, "request stalled without a stalled response")

   // no event means code zero
   `BPHC_ASSERT_IMPLY(a_quiet_code, rsp_valid && !rsp_data.event_valid, rsp_data.event_code == EvPressed, "event code set without an event")

   // event kind agrees with the mode it leaves behind
   `BPHC_ASSERT_IMPLY(a_event_mode, rsp_valid && rsp_data.event_valid, (rsp_data.event_code == EvHeld && rsp_data.button_mode == ModeCodeHeld) || (rsp_data.event_code != EvHeld && rsp_data.button_mode == ModeCodeReleased), "event code disagrees with mode")

endmodule

bind button_press_hold_classifier bphc_checker u_bphc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

/* tb/tb_button_press_hold_classifier.sv */
// self-checking testbench for the button press/hold classifier
module tb_button_press_hold_classifier;
   timeunit 1ns;
   timeprecision 1ps;

   import bphc_pkg::*;

   localparam int ClockPeriod   = 10;
   localparam int StuckLimit    = 2000;
   localparam int HoldoffCycles = 80;
   localparam int DrainCycles   = 6;
   localparam int ReportLimit   = 100;

   typedef enum int {PRESSURE_NONE, PRESSURE_HOLDOFF, PRESSURE_PAUSE} pressure_type;

   class press_scoreboard_type;
      logic [CfgWidth-1:0]   press_ticks;
      logic [CfgWidth-1:0]   hold_ticks;
      logic [1:0]            mode;
      logic [TickWidth-1:0]  ticks;
      logic [CountWidth-1:0] presses;
      rsp_type               expected_events[$];
      int                    errors;

      function new();
         press_ticks = PressTicksReset;
         hold_ticks  = HoldTicksReset;
         mode        = ModeCodeReleased;
         ticks       = '0;
         presses     = '0;
         errors      = 0;
      endfunction

      function int pending();
         return expected_events.size();
      endfunction

      function void bump_ticks();
         if (ticks != TickMax) ticks++;
      endfunction

      function void record_sample(input req_type r);
         rsp_type e;
         e = '0;
         if (r.op == OpLoad) begin
            presses = r.new_count;
         end else if (mode == ModeCodePressed) begin
            bump_ticks();
            if (r.button_level) begin
               if (ticks >= press_ticks) begin
                  e.event_valid = 1'b1;
                  e.event_code  = EvPressed;
               end
               mode = ModeCodeReleased;
            end else if (ticks >= hold_ticks) begin
               mode  = ModeCodeHeld;
               ticks = '0;
               presses++;
            end
         end else if (mode == ModeCodeHeld) begin
            bump_ticks();
            if (r.button_level) begin
               e.event_valid = 1'b1;
               e.event_code  = EvReleased;
               mode          = ModeCodeReleased;
            end else if (ticks >= hold_ticks) begin
               e.event_valid = 1'b1;
               e.event_code  = EvHeld;
               ticks         = '0;
               presses++;
            end
         end else begin
            mode = ModeCodeReleased;
            if (!r.button_level) begin
               mode  = ModeCodePressed;
               ticks = '0;
            end
         end
         e.button_mode = mode;
         e.press_total = presses;
         expected_events.push_back(e);
      endfunction

      task report(input string what, input logic [31:0] got, input logic [31:0] want);
         if (errors < ReportLimit)
            $display("MISMATCH at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got,
                     want);
         errors++;
      endtask

      task check_event(input rsp_type got);
         rsp_type e;
         if (expected_events.size() == 0) begin
            report("unexpected transaction", 32'(got), 32'd0);
         end else begin
            e = expected_events.pop_front();
            if (got.event_valid !== e.event_valid)
               report("event_valid", 32'(got.event_valid), 32'(e.event_valid));
            if (got.event_code !== e.event_code)
               report("event_code", 32'(got.event_code), 32'(e.event_code));
            if (got.button_mode !== e.button_mode)
               report("button_mode", 32'(got.button_mode), 32'(e.button_mode));
            if (got.press_total !== e.press_total)
               report("press_total", 32'(got.press_total), 32'(e.press_total));
         end
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [PaddrWidth-1:0] paddr = '0;
   logic [PdataWidth-1:0] pwdata = '0;
   logic [PdataWidth-1:0] prdata;
   logic                  pready;

   press_scoreboard_type board = new();
   int                    req_idle_pct = 0;
   int                    rsp_stall_pct = 0;
   int                    holdoff_left = 0;
   int                    holdoff_asks = 0;
   int                    holdoff_seen = 0;
   int                    stuck_cycles = 0;
   logic [CfgWidth-1:0]   cur_press = PressTicksReset;
   logic [CfgWidth-1:0]   cur_hold = HoldTicksReset;

   button_press_hold_classifier u_top (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always #(ClockPeriod / 2) clock = ~clock;

   // receiver stall, with a long hold-off on request
   always @(negedge clock) begin
      if (holdoff_left > 0) begin
         rsp_stall    <= 1'b1;
         holdoff_left <= holdoff_left - 1;
      end else if (holdoff_asks != holdoff_seen) begin
         rsp_stall    <= 1'b1;
         holdoff_left <= HoldoffCycles;
         holdoff_seen <= holdoff_asks;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // result monitor and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) board.check_event(rsp_data);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            stuck_cycles = 0;
         else
            stuck_cycles++;
         if (stuck_cycles >= StuckLimit) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   task automatic send_req(input req_type r);
      @(negedge clock);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      board.record_sample(r);
   endtask

   task automatic send_tick(input logic level);
      req_type r;
      r.op           = OpTick;
      r.button_level = level;
      r.new_count    = CountWidth'($urandom());
      send_req(r);
   endtask

   task automatic send_load(input logic [CountWidth-1:0] count, input logic level);
      req_type r;
      r.op           = OpLoad;
      r.button_level = level;
      r.new_count    = count;
      send_req(r);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic csr_write(input logic index, input logic [CfgWidth-1:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= PdataWidth'(value);
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic csr_check(input logic index, input logic [CfgWidth-1:0] value);
      logic [PdataWidth-1:0] got;
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {index, 2'b00};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      got = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      if (got !== PdataWidth'(value)) board.report("register read", got, 32'(value));
   endtask

   task automatic write_setting(input logic [CfgWidth-1:0] p, input logic [CfgWidth-1:0] h);
      wait_drained();
      csr_write(RegPressTicks, p);
      csr_write(RegHoldTicks, h);
      csr_check(RegPressTicks, p);
      csr_check(RegHoldTicks, h);
      board.press_ticks = p;
      board.hold_ticks  = h;
      cur_press         = p;
      cur_hold          = h;
   endtask

   // mostly well-formed press/hold/release sequences, some loads and glitches
   task automatic play_traffic(input int items);
      int                    sent;
      int                    pick;
      int                    len;
      int                    i;
      logic [CountWidth-1:0] count;
      sent = 0;
      while (sent < items) begin
         pick = $urandom_range(99);
         if (pick < 6) begin
            if ($urandom_range(2) == 0)
               count = 16'hFFFF - CountWidth'($urandom_range(3));
            else
               count = CountWidth'($urandom());
            send_load(count, 1'($urandom_range(1)));
            sent++;
         end else if (pick < 14) begin
            send_tick(1'($urandom_range(1)));
            sent++;
         end else begin
            if ($urandom_range(1))
               len = $urandom_range(1, 3 * cur_hold + 3);
            else
               len = $urandom_range(1, cur_press + 3);
            for (i = 0; i < len && sent < items; i++) begin
               send_tick(1'b0);
               sent++;
            end
            len = $urandom_range(1, 4);
            for (i = 0; i < len && sent < items; i++) begin
               send_tick(1'b1);
               sent++;
            end
         end
      end
   endtask

   task automatic run_phase(input logic [CfgWidth-1:0] p, input logic [CfgWidth-1:0] h,
                            input int snd, input int rcv, input int items,
                            input pressure_type pk);
      write_setting(p, h);
      req_idle_pct  = snd;
      rsp_stall_pct = rcv;
      play_traffic(items / 2);
      if (pk == PRESSURE_HOLDOFF)
         holdoff_asks++;
      else if (pk == PRESSURE_PAUSE)
         wait_drained();
      play_traffic(items - items / 2);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // short thresholds: short press, press, hold with count wrap, held, release
      write_setting(8'd2, 8'd3);
      send_tick(1'b1);
      send_load(16'hFFFF, 1'b0);
      send_tick(1'b0);
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b0);
      send_tick(1'b1);
      repeat (7) send_tick(1'b0);
      send_tick(1'b1);
      send_load(16'h5A5A, 1'b1);
      send_load(16'hA5A5, 1'b0);

      // zero thresholds
      write_setting(8'd0, 8'd0);
      repeat (3) send_tick(1'b0);
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b1);
      send_load(16'h0000, 1'b1);

      run_phase(PressTicksReset, HoldTicksReset, 0, 0, 178, PRESSURE_NONE);
      run_phase(8'd1, 8'd1, 68, 0, 178, PRESSURE_NONE);
      run_phase(8'd255, 8'd255, 0, 68, 400, PRESSURE_NONE);
      run_phase(8'd0, 8'd0, 20, 20, 178, PRESSURE_NONE);
      run_phase(CfgWidth'($urandom_range(1, 15)), CfgWidth'($urandom_range(1, 30)), 0, 0,
                178, PRESSURE_HOLDOFF);
      run_phase(CfgWidth'($urandom_range(1, 40)), CfgWidth'($urandom_range(1, 40)), 68, 0,
                178, PRESSURE_PAUSE);
      run_phase(8'd3, 8'd8, 0, 68, 178, PRESSURE_NONE);
      run_phase(CfgWidth'($urandom_range(0, 60)), CfgWidth'($urandom_range(0, 60)), 20, 20,
                178, PRESSURE_NONE);

      wait_drained();
      if (board.errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
